[rtl/core/atfb_pkg.sv]
// Shared types and constants for the API transmit frame builder.
package atfb_pkg;

    // Payload count width: wide enough for the largest supported payload (63).
    localparam int CNT_W = 6;

    // Fixed frame fields.
    localparam logic [7:0]  API_ID         = 8'h01;
    localparam logic [7:0]  CSUM_BASE      = 8'hFF;
    localparam logic [15:0] FRAME_OVERHEAD = 16'd5;

    // Configuration register indexes.
    localparam logic [1:0] CFG_DEST   = 2'd0;
    localparam logic [1:0] CFG_OPTION = 2'd1;
    localparam logic [1:0] CFG_START  = 2'd2;

    // Header byte positions.
    localparam logic [2:0] HDR_START  = 3'd0;
    localparam logic [2:0] HDR_LEN_HI = 3'd1;
    localparam logic [2:0] HDR_LEN_LO = 3'd2;
    localparam logic [2:0] HDR_API_ID = 3'd3;
    localparam logic [2:0] HDR_ID     = 3'd4;
    localparam logic [2:0] HDR_DST_HI = 3'd5;
    localparam logic [2:0] HDR_DST_LO = 3'd6;
    localparam logic [2:0] HDR_OPTION = 3'd7;

    // Back-end sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HDR,
        ST_PAY,
        ST_SUM
    } back_state_t;

    // One finished message, as handed from front to back.
    typedef struct packed {
        logic             bank;
        logic [CNT_W-1:0] count;
        logic [7:0]       frame_id;
        logic [7:0]       csum;
    } frame_desc_t;

    // Payload buffer write request.
    typedef struct packed {
        logic             en;
        logic             bank;
        logic [CNT_W-1:0] slot;
        logic [7:0]       data;
    } buf_wr_t;

endpackage

[rtl/core/api_tx_frame_builder.sv]
// API transmit frame builder: top level with configuration registers.
//
// Payload bytes are taken one per cycle; each message is held in one of two
// buffer banks of MAX_PAYLOAD bytes, and bytes past that are dropped. The byte
// marked last closes the message and queues it; the emitter then sends N+9
// frame bytes (delimiter, length, identifier, frame ID, destination, options,
// payload, checksum) at one byte per cycle, paced by the output ready.
// Input stalls only while two closed messages are waiting
// or being sent, since each holds a buffer bank until its checksum is loaded.
// Configuration is written through cfg_wr_en, cfg_addr and cfg_wdata.
module api_tx_frame_builder
    import atfb_pkg::*;
#(
    parameter int MAX_PAYLOAD = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_payload_byte,
    input  logic        s_payload_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_frame_byte,
    output logic        m_frame_end
);

    logic [15:0] dest_reg, dest_next;
    logic [7:0]  option_reg, option_next;
    logic [7:0]  start_reg, start_next;

    frame_desc_t push_desc, head;
    buf_wr_t     buf_wr;
    logic        q_push, q_pop, q_empty, q_full;

    // Decode configuration writes; drop writes beyond the register list
    always_comb begin
        dest_next   = dest_reg;
        option_next = option_reg;
        start_next  = start_reg;
        if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_DEST:   dest_next   = cfg_wdata;
                CFG_OPTION: option_next = cfg_wdata[7:0];
                CFG_START:  start_next  = cfg_wdata[7:0];
                default:    ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dest_reg   <= 16'h004F;
            option_reg <= 8'h00;
            start_reg  <= 8'h7E;
        end else begin
            dest_reg   <= dest_next;
            option_reg <= option_next;
            start_reg  <= start_next;
        end
    end

    atfb_front #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_payload_byte (s_payload_byte),
        .s_payload_last (s_payload_last),
        .dest_address   (dest_reg),
        .option_byte    (option_reg),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_desc         (push_desc),
        .buf_wr         (buf_wr)
    );

    atfb_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_desc (push_desc),
        .pop       (q_pop),
        .head      (head),
        .empty     (q_empty),
        .full      (q_full)
    );

    atfb_back #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .buf_wr       (buf_wr),
        .head         (head),
        .q_empty      (q_empty),
        .q_pop        (q_pop),
        .dest_address (dest_reg),
        .option_byte  (option_reg),
        .start_byte   (start_reg),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_frame_byte (m_frame_byte),
        .m_frame_end  (m_frame_end)
    );

endmodule

[rtl/core/atfb_front.sv]
// Front end: takes payload bytes, fills a message buffer, closes each message.
module atfb_front
    import atfb_pkg::*;
#(
    parameter int MAX_PAYLOAD = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [7:0]        s_payload_byte,
    input  logic              s_payload_last,
    input  logic [15:0]       dest_address,
    input  logic [7:0]        option_byte,
    input  logic              q_full,
    output logic              q_push,
    output frame_desc_t       q_desc,
    output buf_wr_t           buf_wr
);

    logic [CNT_W-1:0] count_reg, count_next, count_upd;
    logic [7:0]       sum_reg, sum_next, sum_upd;
    logic [7:0]       id_reg, id_next, id_inc;
    logic             bank_reg, bank_next;
    logic             accept, room;
    logic [7:0]       hdr_sum;

    // Accept while a message buffer is free
    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign room    = count_reg < CNT_W'(MAX_PAYLOAD);

    // Store the byte if there is room, drop it otherwise
    assign count_upd = room ? count_reg + CNT_W'(1) : count_reg;
    assign sum_upd   = room ? sum_reg + s_payload_byte : sum_reg;

    assign buf_wr.en   = accept && room;
    assign buf_wr.bank = bank_reg;
    assign buf_wr.slot = count_reg;
    assign buf_wr.data = s_payload_byte;

    // Checksum over identifier, frame ID, destination, options and payload
    assign hdr_sum = API_ID + id_reg + dest_address[15:8] + dest_address[7:0]
                   + option_byte + sum_upd;

    // Close the message on the marked byte
    assign q_push          = accept && s_payload_last;
    assign q_desc.bank     = bank_reg;
    assign q_desc.count    = count_upd;
    assign q_desc.frame_id = id_reg;
    assign q_desc.csum     = CSUM_BASE - hdr_sum;

    // Frame ID wraps past zero to one
    assign id_inc = id_reg + 8'd1;

    always_comb begin
        count_next = count_reg;
        sum_next   = sum_reg;
        id_next    = id_reg;
        bank_next  = bank_reg;
        if (accept) begin
            if (s_payload_last) begin
                count_next = '0;
                sum_next   = '0;
                id_next    = (id_inc == 8'd0) ? 8'd1 : id_inc;
                bank_next  = !bank_reg;
            end else begin
                count_next = count_upd;
                sum_next   = sum_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            sum_reg   <= '0;
            id_reg    <= 8'd1;
            bank_reg  <= 1'b0;
        end else begin
            count_reg <= count_next;
            sum_reg   <= sum_next;
            id_reg    <= id_next;
            bank_reg  <= bank_next;
        end
    end

endmodule

[rtl/core/atfb_queue.sv]
// Two-entry queue of closed messages between front and back.
module atfb_queue
    import atfb_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  frame_desc_t push_desc,
    input  logic        pop,
    output frame_desc_t head,
    output logic        empty,
    output logic        full
);

    frame_desc_t entry_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  cnt_reg, cnt_next;

    assign head  = entry_reg[rd_ptr_reg];
    assign empty = (cnt_reg == 2'd0);
    assign full  = (cnt_reg == 2'd2);

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Hold descriptors
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

[rtl/core/atfb_back.sv]
// Back end: payload buffer and the sequencer that emits each frame byte by byte.
module atfb_back
    import atfb_pkg::*;
#(
    parameter int MAX_PAYLOAD = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  buf_wr_t     buf_wr,
    input  frame_desc_t head,
    input  logic        q_empty,
    output logic        q_pop,
    input  logic [15:0] dest_address,
    input  logic [7:0]  option_byte,
    input  logic [7:0]  start_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_frame_byte,
    output logic        m_frame_end
);

    localparam int IW    = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int DEPTH = 2 ** (IW + 1);

    logic [7:0]       mem [DEPTH];
    logic [7:0]       mem_q_reg;
    logic [IW:0]      rd_addr;

    back_state_t      state_reg, state_next;
    logic [2:0]       hdr_idx_reg, hdr_idx_next;
    logic [CNT_W-1:0] pay_idx_reg, pay_idx_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_byte_reg, out_byte_next;
    logic             out_end_reg, out_end_next;
    logic             can_load;
    logic [15:0]      frame_len;
    logic [7:0]       hdr_byte;

    assign m_valid      = out_valid_reg;
    assign m_frame_byte = out_byte_reg;
    assign m_frame_end  = out_end_reg;

    assign can_load  = !out_valid_reg || m_ready;
    assign frame_len = 16'(head.count) + FRAME_OVERHEAD;

    // Payload buffer: two banks, one per outstanding message
    always_ff @(posedge aclk) begin
        if (buf_wr.en) begin
            mem[{buf_wr.bank, buf_wr.slot[IW-1:0]}] <= buf_wr.data;
        end
    end

    // Read ahead so the current payload slot is ready when loaded
    assign rd_addr = {head.bank, pay_idx_next[IW-1:0]};

    always_ff @(posedge aclk) begin
        mem_q_reg <= mem[rd_addr];
    end

    // Select the header byte
    always_comb begin
        case (hdr_idx_reg)
            HDR_START:  hdr_byte = start_byte;
            HDR_LEN_HI: hdr_byte = frame_len[15:8];
            HDR_LEN_LO: hdr_byte = frame_len[7:0];
            HDR_API_ID: hdr_byte = API_ID;
            HDR_ID:     hdr_byte = head.frame_id;
            HDR_DST_HI: hdr_byte = dest_address[15:8];
            HDR_DST_LO: hdr_byte = dest_address[7:0];
            HDR_OPTION: hdr_byte = option_byte;
            default:    hdr_byte = option_byte;
        endcase
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (!q_empty) begin
                    state_next = ST_HDR;
                end
            end
            ST_HDR: begin
                if (can_load && hdr_idx_reg == HDR_OPTION) begin
                    state_next = ST_PAY;
                end
            end
            ST_PAY: begin
                if (can_load && pay_idx_reg == head.count - CNT_W'(1)) begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM: begin
                if (can_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs, counters and the output register
    always_comb begin
        hdr_idx_next   = hdr_idx_reg;
        pay_idx_next   = pay_idx_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_byte_next  = out_byte_reg;
        out_end_next   = out_end_reg;
        q_pop          = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                hdr_idx_next = HDR_START;
                pay_idx_next = '0;
            end
            ST_HDR: begin
                if (can_load) begin
                    out_valid_next = 1'b1;
                    out_byte_next  = hdr_byte;
                    out_end_next   = 1'b0;
                    hdr_idx_next   = hdr_idx_reg + 3'd1;
                end
            end
            ST_PAY: begin
                if (can_load) begin
                    out_valid_next = 1'b1;
                    out_byte_next  = mem_q_reg;
                    out_end_next   = 1'b0;
                    if (pay_idx_reg != head.count - CNT_W'(1)) begin
                        pay_idx_next = pay_idx_reg + CNT_W'(1);
                    end
                end
            end
            ST_SUM: begin
                if (can_load) begin
                    out_valid_next = 1'b1;
                    out_byte_next  = head.csum;
                    out_end_next   = 1'b1;
                    q_pop          = 1'b1;
                    pay_idx_next   = '0;
                end
            end
            default: begin
                hdr_idx_next = HDR_START;
                pay_idx_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            hdr_idx_reg   <= HDR_START;
            pay_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            hdr_idx_reg   <= hdr_idx_next;
            pay_idx_reg   <= pay_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_byte_reg <= out_byte_next;
        out_end_reg  <= out_end_next;
    end

endmodule
